// File: sv/assert_macros.svh
// Assertion helpers, compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property checked on every rising clock edge, disabled during reset.
`define KNC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("knc assertion failed");

// Same check, but also active while reset is asserted.
`define KNC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("knc assertion failed");

`else

`define KNC_ASSERT(lbl, prop)
`define KNC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// File: sv/knc_pkg.sv
`timescale 1ns / 1ps

package knc_pkg;

  localparam int MAX_KEPT   = 8;
  localparam int COORD_W    = 16;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int DIST_W     = 2 * COORD_W + 2;
  localparam int CNT_W      = $clog2(MAX_KEPT + 1);
  localparam int IDX_W      = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int WANT_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic KIND_TRIM  = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [DIST_W-1:0]         dsq;
  } entry_t;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_NEW,
    SEL_LEFT,
    SEL_RIGHT
  } cell_sel_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_X,
    REG_TARGET_Y,
    REG_TARGET_Z,
    REG_WANTED
  } cfg_reg_e;

endpackage

// File: sv/knc_cell.sv
`timescale 1ns / 1ps

module knc_cell (
  input  logic                       clk_i,
  input  knc_pkg::cell_sel_e         sel_i,
  input  knc_pkg::entry_t            new_i,
  input  knc_pkg::entry_t            left_i,
  input  knc_pkg::entry_t            right_i,
  input  logic [knc_pkg::DIST_W-1:0] d_i,
  output knc_pkg::entry_t            entry_o,
  output logic                       lt_o,
  output logic                       le_o
);

  knc_pkg::entry_t entry_q, entry_d;

  always_comb begin
    case (sel_i)
      knc_pkg::SEL_NEW:   entry_d = new_i;
      knc_pkg::SEL_LEFT:  entry_d = left_i;
      knc_pkg::SEL_RIGHT: entry_d = right_i;
      default:            entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign lt_o    = entry_q.dsq < d_i;
  assign le_o    = entry_q.dsq <= d_i;

endmodule

// File: sv/k_nearest_candidate_list_top.sv
`timescale 1ns / 1ps
// The trim answer is registered once the request has passed the diff, square, sum and
// insert steps; a new request is stalled until the row is back in idle, and a query end
// first shifts every kept entry out of the row. Output stalls hold insert and shift-out.
// Reset clears control state and the kept count; targets go to 0, wanted count to 1.
// Kept entries hold no reset value; only entries below the count are ever read.
`include "assert_macros.svh"

module k_nearest_candidate_list_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [knc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [knc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [knc_pkg::COORD_W-1:0]    point_x_i,
  input  logic signed [knc_pkg::COORD_W-1:0]    point_y_i,
  input  logic signed [knc_pkg::COORD_W-1:0]    point_z_i,
  input  logic                                  query_end_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  result_kind_o,
  output logic                                  trim_ok_o,
  output logic signed [knc_pkg::COORD_W-1:0]    entry_x_o,
  output logic signed [knc_pkg::COORD_W-1:0]    entry_y_o,
  output logic signed [knc_pkg::COORD_W-1:0]    entry_z_o,
  output logic [knc_pkg::DIST_W-1:0]            entry_dist_o,
  output logic                                  run_last_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam int CNT_W = knc_pkg::CNT_W;
  localparam int IDX_W = knc_pkg::IDX_W;
  localparam int CW    = knc_pkg::COORD_W;

  // configuration
  logic signed [CW-1:0]          tgt_x_q, tgt_y_q, tgt_z_q;
  logic [knc_pkg::WANT_W-1:0]    want_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_x_q <= '0;
      tgt_y_q <= '0;
      tgt_z_q <= '0;
      want_q  <= knc_pkg::WANT_W'(1);
    end else if (cfg_we_i) begin
      unique case (knc_pkg::cfg_reg_e'(cfg_idx_i))
        knc_pkg::REG_TARGET_X: tgt_x_q <= cfg_data_i;
        knc_pkg::REG_TARGET_Y: tgt_y_q <= cfg_data_i;
        knc_pkg::REG_TARGET_Z: tgt_z_q <= cfg_data_i;
        knc_pkg::REG_WANTED:   want_q  <= cfg_data_i[knc_pkg::WANT_W-1:0];
      endcase
    end
  end

  // control
  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             in_acc, slot_free;

  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_o || !out_stall_i;

  // distance datapath
  logic signed [CW-1:0]          pt_x_q, pt_y_q, pt_z_q;
  logic                          qend_q;
  logic signed [CW:0]            dx_q, dy_q, dz_q;
  logic signed [2*CW+1:0]        prod_x, prod_y, prod_z;
  logic [knc_pkg::SQ_W-1:0]      sq_x_q, sq_y_q, sq_z_q;
  logic [knc_pkg::DIST_W-1:0]    sum_q;

  assign prod_x = dx_q * dx_q;
  assign prod_y = dy_q * dy_q;
  assign prod_z = dz_q * dz_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pt_x_q <= point_x_i;
      pt_y_q <= point_y_i;
      pt_z_q <= point_z_i;
      qend_q <= query_end_i;
      dx_q   <= {point_x_i[CW-1], point_x_i} - {tgt_x_q[CW-1], tgt_x_q};
      dy_q   <= {point_y_i[CW-1], point_y_i} - {tgt_y_q[CW-1], tgt_y_q};
      dz_q   <= {point_z_i[CW-1], point_z_i} - {tgt_z_q[CW-1], tgt_z_q};
    end
    if (state_q == S_SQ) begin
      sq_x_q <= prod_x[knc_pkg::SQ_W-1:0];
      sq_y_q <= prod_y[knc_pkg::SQ_W-1:0];
      sq_z_q <= prod_z[knc_pkg::SQ_W-1:0];
    end
    if (state_q == S_SUM) begin
      sum_q <= {2'b00, sq_x_q} + {2'b00, sq_y_q} + {2'b00, sq_z_q};
    end
  end

  // cell row
  knc_pkg::entry_t    new_e;
  knc_pkg::entry_t    cell_e [knc_pkg::MAX_KEPT];
  knc_pkg::cell_sel_e sel    [knc_pkg::MAX_KEPT];
  logic [knc_pkg::MAX_KEPT-1:0] lt, le;

  assign new_e = '{x: pt_x_q, y: pt_y_q, z: pt_z_q, dsq: sum_q};

  for (genvar g = 0; g < knc_pkg::MAX_KEPT; g++) begin : g_cell
    knc_pkg::entry_t left_e, right_e;
    if (g == 0) begin : g_first
      assign left_e = new_e;
    end else begin : g_mid
      assign left_e = cell_e[g-1];
    end
    if (g == knc_pkg::MAX_KEPT - 1) begin : g_last
      assign right_e = cell_e[g];
    end else begin : g_inner
      assign right_e = cell_e[g+1];
    end
    knc_cell u_cell (
      .clk_i   (clk_i),
      .sel_i   (sel[g]),
      .new_i   (new_e),
      .left_i  (left_e),
      .right_i (right_e),
      .d_i     (sum_q),
      .entry_o (cell_e[g]),
      .lt_o    (lt[g]),
      .le_o    (le[g])
    );
  end

  // insertion decision
  logic [CNT_W-1:0]             n_eff, cnt_eff, cnt_new;
  logic                         full, accept, trim;
  logic [knc_pkg::MAX_KEPT-1:0] ltm;
  logic                         prev;

  always_comb begin
    if (int'(want_q) > knc_pkg::MAX_KEPT) n_eff = CNT_W'(knc_pkg::MAX_KEPT);
    else                                  n_eff = CNT_W'(want_q);
    full   = cnt_q >= n_eff;
    accept = (n_eff != '0) &&
             (!full || ((cnt_q != '0) && !le[IDX_W'(cnt_q - CNT_W'(1))]));
    cnt_eff = (full && accept) ? cnt_q - CNT_W'(1) : cnt_q;
    for (int i = 0; i < knc_pkg::MAX_KEPT; i++) begin
      ltm[i] = lt[i] && (CNT_W'(i) < cnt_eff);
    end
    if (!accept)             trim = 1'b1;
    else if (!full)          trim = 1'b0;
    else if (cnt_eff == '0)  trim = 1'b1;
    else                     trim = ltm[IDX_W'(cnt_eff - CNT_W'(1))];
    cnt_new = accept ? cnt_eff + CNT_W'(1) : cnt_q;
  end

  // output register
  logic            out_valid_d, kind_q, kind_d, trim_q, trim_d, last_q, last_d;
  knc_pkg::entry_t oent_q, oent_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_o && out_stall_i;
    kind_d      = kind_q;
    trim_d      = trim_q;
    last_d      = last_q;
    oent_d      = oent_q;
    prev        = 1'b1;
    for (int i = 0; i < knc_pkg::MAX_KEPT; i++) sel[i] = knc_pkg::SEL_HOLD;

    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_SQ;
      S_SQ:   state_d = S_SUM;
      S_SUM:  state_d = S_INS;
      S_INS: begin
        if (slot_free) begin
          if (accept) begin
            // entries closer than the new point stay, the slot after them loads it
            for (int i = 0; i < knc_pkg::MAX_KEPT; i++) begin
              if (ltm[i])    sel[i] = knc_pkg::SEL_HOLD;
              else if (prev) sel[i] = knc_pkg::SEL_NEW;
              else           sel[i] = knc_pkg::SEL_LEFT;
              prev = ltm[i];
            end
          end
          out_valid_d = 1'b1;
          kind_d      = knc_pkg::KIND_TRIM;
          trim_d      = trim;
          last_d      = !qend_q || (cnt_new == '0);
          oent_d      = '0;
          if (qend_q && (cnt_new != '0)) begin
            cnt_d   = cnt_new;
            state_d = S_EMIT;
          end else begin
            cnt_d   = qend_q ? '0 : cnt_new;
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          for (int i = 0; i < knc_pkg::MAX_KEPT; i++) sel[i] = knc_pkg::SEL_RIGHT;
          out_valid_d = 1'b1;
          kind_d      = knc_pkg::KIND_ENTRY;
          trim_d      = 1'b0;
          last_d      = cnt_q == CNT_W'(1);
          oent_d      = cell_e[0];
          cnt_d       = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_o <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    trim_q <= trim_d;
    last_q <= last_d;
    oent_q <= oent_d;
  end

  assign result_kind_o = kind_q;
  assign trim_ok_o     = trim_q;
  assign entry_x_o     = oent_q.x;
  assign entry_y_o     = oent_q.y;
  assign entry_z_o     = oent_q.z;
  assign entry_dist_o  = oent_q.dsq;
  assign run_last_o    = last_q;

  `KNC_ASSERT(a_cnt_bound, int'(cnt_q) <= knc_pkg::MAX_KEPT)
  `KNC_ASSERT(a_emit_nonempty, (state_q == S_EMIT) |-> (cnt_q != '0))
  `KNC_ASSERT(a_trim_first, (state_q == S_INS && slot_free) |=> (out_valid_o && !result_kind_o))
  `KNC_ASSERT(a_emit_sorted, (state_q == S_EMIT && slot_free && cnt_q > CNT_W'(1)) |=> (cell_e[0].dsq >= $past(cell_e[0].dsq)))

endmodule
